[sv/tti_pkg.sv]
// Shared types and constants for the trilinear table interpolator.
// Used by the controller, the datapath and the interpolation unit.
`default_nettype none

package tti_pkg;

    localparam int BPW   = 20;
    localparam int COEFW = 24;
    localparam int STW   = 2;
    localparam int REQW  = 3;
    localparam int CFGIW = 2;
    localparam int CFGDW = 6;

    localparam logic [REQW-1:0] REQ_MACH_BP = 3'd0;
    localparam logic [REQW-1:0] REQ_AOA_BP  = 3'd1;
    localparam logic [REQW-1:0] REQ_DEFL_BP = 3'd2;
    localparam logic [REQW-1:0] REQ_COEF    = 3'd3;
    localparam logic [REQW-1:0] REQ_QUERY   = 3'd4;

    localparam logic [STW-1:0] STS_INSIDE = 2'd0;
    localparam logic [STW-1:0] STS_EXTRAP = 2'd1;
    localparam logic [STW-1:0] STS_ZERO   = 2'd2;

    localparam logic [CFGIW-1:0] CFG_MACH_COUNT = 2'd0;
    localparam logic [CFGIW-1:0] CFG_AOA_COUNT  = 2'd1;
    localparam logic [CFGIW-1:0] CFG_DEFL_COUNT = 2'd2;

    typedef enum logic [1:0] {AX_MACH, AX_AOA, AX_DEFL} axis_t;
    typedef enum logic [1:0] {LV_DEFL, LV_AOA, LV_MACH} lvl_t;

    typedef struct packed {
        logic       wr;
        logic       cap;
        logic       scan;
        axis_t      axis;
        logic       slice;
        logic       row;
        logic [1:0] coef;
        logic       rd_lo;
        logic       rd_hi;
        logic       lerp;
        lvl_t       lvl;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic lerp_done;
    } sts_t;

    // Index of the last breakpoint in use after clamping the count to [2, lim].
    function automatic int used_last(int raw, int lim);
        if (raw < 2) return 1;
        if (raw > lim) return lim - 1;
        return raw - 1;
    endfunction

endpackage

`default_nettype wire

[sv/tti_lerp.sv]
// One linear interpolation step with a bit-serial rounding divider.
// Depends on tti_pkg for field widths.
`default_nettype none

module tti_lerp
    import tti_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [BPW-1:0]   x0,
    input  wire logic signed [BPW-1:0]   x1,
    input  wire logic signed [BPW-1:0]   xq,
    input  wire logic signed [COEFW-1:0] y0,
    input  wire logic signed [COEFW-1:0] y1,
    output logic                         done,
    output logic signed [COEFW-1:0]      y,
    output logic                         zw
);

    localparam int DXW  = BPW + 1;
    localparam int DYW  = COEFW + 1;
    localparam int NW   = DXW + DYW;
    localparam int QW   = NW + 1;
    localparam int RW   = DXW + 1;
    localparam int SUMW = QW + 2;
    localparam int CNTW = $clog2(QW + 1);
    localparam logic signed [SUMW-1:0] SMAX = SUMW'(2 ** (COEFW - 1) - 1);
    localparam logic signed [SUMW-1:0] SMIN = -SUMW'(2 ** (COEFW - 1));

    typedef enum logic [2:0] {L_IDLE, L_MUL, L_ABS, L_DIV, L_FIN} lstate_t;

    lstate_t                  state_reg;
    logic signed [DXW-1:0]    dx_reg;
    logic signed [DXW-1:0]    den_reg;
    logic signed [DYW-1:0]    dy_reg;
    logic signed [COEFW-1:0]  y0_reg;
    logic signed [NW-1:0]     num_reg;
    logic [DXW-1:0]           ad_reg;
    logic                     neg_reg;
    logic [DXW-1:0]           rem_reg;
    logic [QW-1:0]            dvd_reg;
    logic [CNTW-1:0]          cnt_reg;
    logic signed [COEFW-1:0]  y_reg;
    logic                     zw_reg;
    logic                     done_reg;

    logic signed [NW-1:0]     prod;
    logic [NW-1:0]            an;
    logic [RW-1:0]            shifted;
    logic                     ge;
    logic [RW-1:0]            trial;
    logic signed [SUMW-1:0]   qs;
    logic signed [SUMW-1:0]   sum;

    assign prod    = NW'(dy_reg) * NW'(dx_reg);
    assign an      = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign shifted = {rem_reg, dvd_reg[QW-1]};
    assign ge      = shifted >= {1'b0, ad_reg};
    assign trial   = shifted - {1'b0, ad_reg};
    assign qs      = neg_reg ? -$signed({2'b00, dvd_reg}) : $signed({2'b00, dvd_reg});
    assign sum     = SUMW'(y0_reg) + qs;

    always_ff @(posedge aclk) begin
        done_reg <= 1'b0;
        case (state_reg)
            L_IDLE: begin
                if (start) begin
                    dx_reg    <= DXW'(xq) - DXW'(x0);
                    den_reg   <= DXW'(x1) - DXW'(x0);
                    dy_reg    <= DYW'(y1) - DYW'(y0);
                    y0_reg    <= y0;
                    state_reg <= L_MUL;
                end
            end
            L_MUL: begin
                num_reg <= prod;
                if (den_reg == '0) begin
                    y_reg     <= y0_reg;
                    zw_reg    <= 1'b1;
                    done_reg  <= 1'b1;
                    state_reg <= L_IDLE;
                end else begin
                    ad_reg    <= den_reg[DXW-1] ? DXW'(-den_reg) : DXW'(den_reg);
                    neg_reg   <= den_reg[DXW-1];
                    state_reg <= L_ABS;
                end
            end
            L_ABS: begin
                neg_reg   <= neg_reg ^ num_reg[NW-1];
                dvd_reg   <= QW'(an) + QW'(ad_reg >> 1);
                rem_reg   <= '0;
                cnt_reg   <= CNTW'(QW);
                state_reg <= L_DIV;
            end
            L_DIV: begin
                rem_reg <= ge ? trial[DXW-1:0] : shifted[DXW-1:0];
                dvd_reg <= {dvd_reg[QW-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1)) begin
                    state_reg <= L_FIN;
                end
            end
            L_FIN: begin
                if (sum > SMAX) begin
                    y_reg <= SMAX[COEFW-1:0];
                end else if (sum < SMIN) begin
                    y_reg <= SMIN[COEFW-1:0];
                end else begin
                    y_reg <= sum[COEFW-1:0];
                end
                zw_reg    <= 1'b0;
                done_reg  <= 1'b1;
                state_reg <= L_IDLE;
            end
            default: state_reg <= L_IDLE;
        endcase
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
    end

    assign done = done_reg;
    assign y    = y_reg;
    assign zw   = zw_reg;

endmodule

`default_nettype wire

[sv/tti_datapath.sv]
// Datapath: configuration registers, breakpoint and coefficient memories,
// the breakpoint scanner, the interpolation unit and the result register.
// Depends on tti_pkg and tti_lerp.
`default_nettype none

module tti_datapath
    import tti_pkg::*;
#(
    parameter int MACH_MAX = 16,
    parameter int AOA_MAX  = 32,
    parameter int DEFL_MAX = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFGIW-1:0]        cfg_index,
    input  wire logic [CFGDW-1:0]        cfg_wr_data,
    input  wire logic [REQW-1:0]         s_req_type,
    input  wire logic [3:0]              s_row_mach,
    input  wire logic [4:0]              s_row_aoa,
    input  wire logic [3:0]              s_row_defl,
    input  wire logic signed [BPW-1:0]   s_bp_value,
    input  wire logic signed [COEFW-1:0] s_coef_lift,
    input  wire logic signed [COEFW-1:0] s_coef_drag,
    input  wire logic signed [COEFW-1:0] s_coef_moment,
    input  wire logic signed [BPW-1:0]   s_query_mach,
    input  wire logic signed [BPW-1:0]   s_query_aoa,
    input  wire logic signed [BPW-1:0]   s_query_defl,
    input  wire cmd_t                    cmd,
    output sts_t                         sts,
    output logic signed [COEFW-1:0]      m_lift_out,
    output logic signed [COEFW-1:0]      m_drag_out,
    output logic signed [COEFW-1:0]      m_moment_out,
    output logic [STW-1:0]               m_status
);

    localparam int MW   = $clog2(MACH_MAX);
    localparam int AW   = $clog2(AOA_MAX);
    localparam int DW   = $clog2(DEFL_MAX);
    localparam int SW   = (MW > AW) ? ((MW > DW) ? MW : DW) : ((AW > DW) ? AW : DW);
    localparam int BPAN = MACH_MAX * AOA_MAX;
    localparam int BPAW = $clog2(BPAN);
    localparam int TN   = BPAN * DEFL_MAX;
    localparam int TAW  = $clog2(TN);

    logic [4:0] mach_cnt_reg;
    logic [5:0] aoa_cnt_reg;
    logic [4:0] defl_cnt_reg;
    logic [SW-1:0] m_last;
    logic [SW-1:0] a_last;
    logic [SW-1:0] d_last;

    logic signed [BPW-1:0]   mbp_mem [MACH_MAX];
    logic signed [BPW-1:0]   abp_mem [BPAN];
    logic signed [BPW-1:0]   dbp_mem [DEFL_MAX];
    logic signed [COEFW-1:0] lift_mem [TN];
    logic signed [COEFW-1:0] drag_mem [TN];
    logic signed [COEFW-1:0] mom_mem [TN];
    logic signed [BPW-1:0]   mbp_q, abp_q, dbp_q;
    logic signed [COEFW-1:0] tl_q, td_q, tm_q;

    logic wr_m, wr_a, wr_d, wr_t;
    logic [BPAW-1:0] abp_waddr, abp_raddr;
    logic [TAW-1:0]  t_waddr, t_raddr;
    logic [MW-1:0]   m_sel;
    logic [AW-1:0]   a_sel;

    logic signed [BPW-1:0] qm_reg, qa_reg, qd_reg;
    logic ext_reg, zw_reg;

    logic          sc_run_reg;
    logic [SW-1:0] sc_cnt_reg;
    axis_t         sc_ax_reg;
    logic          pv_reg;
    logic [SW-1:0] pidx_reg;
    logic [SW-1:0] sc_idx_reg, sc_idx_next;
    logic signed [BPW-1:0] sc_lo_reg, sc_lo_next;
    logic signed [BPW-1:0] sc_hi_reg, sc_hi_next;
    logic signed [BPW-1:0] sc_first_reg, sc_first_next;
    logic sc_done_reg;
    logic [SW-1:0] sc_last;
    logic signed [BPW-1:0] sc_d, sc_x;
    logic p_end;

    logic [MW-1:0] mi_reg;
    logic [DW-1:0] di_reg;
    logic [AW-1:0] ai_reg [2];
    logic signed [BPW-1:0] m0_reg, m1_reg, d0_reg, d1_reg;
    logic signed [BPW-1:0] a0_reg [2];
    logic signed [BPW-1:0] a1_reg [2];

    logic tv_lo_reg, tv_hi_reg;
    logic signed [COEFW-1:0] tlo_reg [3];
    logic signed [COEFW-1:0] thi_reg [3];
    logic signed [COEFW-1:0] row_reg [2][3];
    logic signed [COEFW-1:0] slc_reg [2][3];
    logic signed [COEFW-1:0] res_reg [3];

    lvl_t       lt_lvl_reg;
    logic       lt_s_reg, lt_r_reg;
    logic [1:0] lt_c_reg;

    logic signed [BPW-1:0]   l_x0, l_x1, l_xq;
    logic signed [COEFW-1:0] l_y0, l_y1, l_y;
    logic l_done, l_zw;

    logic signed [COEFW-1:0] out_lift_reg, out_drag_reg, out_mom_reg;
    logic [STW-1:0]          out_sts_reg;

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mach_cnt_reg <= 5'd2;
            aoa_cnt_reg  <= 6'd2;
            defl_cnt_reg <= 5'd2;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MACH_COUNT: mach_cnt_reg <= cfg_wr_data[4:0];
                CFG_AOA_COUNT:  aoa_cnt_reg  <= cfg_wr_data;
                CFG_DEFL_COUNT: defl_cnt_reg <= cfg_wr_data[4:0];
                default: ;
            endcase
        end
    end

    assign m_last = SW'(used_last(int'(mach_cnt_reg), MACH_MAX));
    assign a_last = SW'(used_last(int'(aoa_cnt_reg), AOA_MAX));
    assign d_last = SW'(used_last(int'(defl_cnt_reg), DEFL_MAX));

    // Write decode
    always_comb begin
        wr_m = 1'b0;
        wr_a = 1'b0;
        wr_d = 1'b0;
        wr_t = 1'b0;
        if (cmd.wr) begin
            unique case (s_req_type)
                REQ_MACH_BP: wr_m = int'(s_row_mach) < MACH_MAX;
                REQ_AOA_BP:  wr_a = (int'(s_row_mach) < MACH_MAX) && (int'(s_row_aoa) < AOA_MAX);
                REQ_DEFL_BP: wr_d = int'(s_row_defl) < DEFL_MAX;
                REQ_COEF:    wr_t = (int'(s_row_mach) < MACH_MAX) &&
                                    (int'(s_row_aoa) < AOA_MAX) &&
                                    (int'(s_row_defl) < DEFL_MAX);
                default: ;
            endcase
        end
    end

    assign abp_waddr = BPAW'(int'(s_row_mach) * AOA_MAX + int'(s_row_aoa));
    assign t_waddr   = TAW'((int'(s_row_mach) * AOA_MAX + int'(s_row_aoa)) * DEFL_MAX
                            + int'(s_row_defl));
    assign m_sel     = mi_reg + MW'(cmd.slice);
    assign a_sel     = ai_reg[cmd.slice] + AW'(cmd.row);
    assign abp_raddr = BPAW'(int'(m_sel) * AOA_MAX + int'(sc_cnt_reg[AW-1:0]));
    assign t_raddr   = TAW'((int'(m_sel) * AOA_MAX + int'(a_sel)) * DEFL_MAX
                            + int'(di_reg) + int'(cmd.rd_hi));

    // Memories
    always_ff @(posedge aclk) begin
        if (wr_m) begin
            mbp_mem[MW'(s_row_mach)] <= s_bp_value;
        end
        mbp_q <= mbp_mem[sc_cnt_reg[MW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            abp_mem[abp_waddr] <= s_bp_value;
        end
        abp_q <= abp_mem[abp_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wr_d) begin
            dbp_mem[DW'(s_row_defl)] <= s_bp_value;
        end
        dbp_q <= dbp_mem[sc_cnt_reg[DW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (wr_t) begin
            lift_mem[t_waddr] <= s_coef_lift;
            drag_mem[t_waddr] <= s_coef_drag;
            mom_mem[t_waddr]  <= s_coef_moment;
        end
        tl_q <= lift_mem[t_raddr];
        td_q <= drag_mem[t_raddr];
        tm_q <= mom_mem[t_raddr];
    end

    // Breakpoint scan
    always_comb begin
        unique case (sc_ax_reg)
            AX_MACH: begin sc_d = mbp_q; sc_x = qm_reg; sc_last = m_last; end
            AX_AOA:  begin sc_d = abp_q; sc_x = qa_reg; sc_last = a_last; end
            AX_DEFL: begin sc_d = dbp_q; sc_x = qd_reg; sc_last = d_last; end
            default: begin sc_d = dbp_q; sc_x = qd_reg; sc_last = d_last; end
        endcase
    end

    always_comb begin
        sc_idx_next   = sc_idx_reg;
        sc_lo_next    = sc_lo_reg;
        sc_hi_next    = sc_hi_reg;
        sc_first_next = sc_first_reg;
        if (pv_reg) begin
            if (pidx_reg == '0) begin
                sc_first_next = sc_d;
                sc_lo_next    = sc_d;
                sc_idx_next   = '0;
            end else begin
                if (pidx_reg == SW'(sc_idx_reg + 1'b1)) begin
                    sc_hi_next = sc_d;
                end
                if (pidx_reg < sc_last && sc_d <= sc_x) begin
                    sc_idx_next = pidx_reg;
                    sc_lo_next  = sc_d;
                end
            end
        end
    end

    assign p_end = pv_reg && (pidx_reg == sc_last);

    always_ff @(posedge aclk) begin
        pv_reg       <= sc_run_reg;
        pidx_reg     <= sc_cnt_reg;
        sc_done_reg  <= p_end;
        sc_idx_reg   <= sc_idx_next;
        sc_lo_reg    <= sc_lo_next;
        sc_hi_reg    <= sc_hi_next;
        sc_first_reg <= sc_first_next;
        if (cmd.scan) begin
            sc_run_reg <= 1'b1;
            sc_cnt_reg <= '0;
            sc_ax_reg  <= cmd.axis;
        end else if (sc_run_reg) begin
            sc_cnt_reg <= sc_cnt_reg + 1'b1;
            if (sc_cnt_reg == sc_last) begin
                sc_run_reg <= 1'b0;
            end
        end
        if (p_end) begin
            unique case (sc_ax_reg)
                AX_MACH: begin
                    mi_reg <= sc_idx_next[MW-1:0];
                    m0_reg <= sc_lo_next;
                    m1_reg <= sc_hi_next;
                end
                AX_AOA: begin
                    ai_reg[cmd.slice] <= sc_idx_next[AW-1:0];
                    a0_reg[cmd.slice] <= sc_lo_next;
                    a1_reg[cmd.slice] <= sc_hi_next;
                end
                AX_DEFL: begin
                    di_reg <= sc_idx_next[DW-1:0];
                    d0_reg <= sc_lo_next;
                    d1_reg <= sc_hi_next;
                end
                default: ;
            endcase
        end
        if (cmd.cap) begin
            qm_reg <= s_query_mach;
            qa_reg <= s_query_aoa;
            qd_reg <= s_query_defl;
        end
        if (!aresetn) begin
            sc_run_reg  <= 1'b0;
            pv_reg      <= 1'b0;
            sc_done_reg <= 1'b0;
            sc_cnt_reg  <= '0;
            sc_ax_reg   <= AX_MACH;
        end
    end

    // Status flags of the query in progress
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.cap) begin
            ext_reg <= 1'b0;
            zw_reg  <= 1'b0;
        end else begin
            if (p_end && (sc_x < sc_first_reg || sc_x > sc_d)) begin
                ext_reg <= 1'b1;
            end
            if (l_done && l_zw) begin
                zw_reg <= 1'b1;
            end
        end
    end

    // Coefficient reads and interpolation results
    always_comb begin
        unique case (cmd.lvl)
            LV_DEFL: begin
                l_x0 = d0_reg;
                l_x1 = d1_reg;
                l_xq = qd_reg;
                l_y0 = tlo_reg[cmd.coef];
                l_y1 = thi_reg[cmd.coef];
            end
            LV_AOA: begin
                l_x0 = a0_reg[cmd.slice];
                l_x1 = a1_reg[cmd.slice];
                l_xq = qa_reg;
                l_y0 = row_reg[0][cmd.coef];
                l_y1 = row_reg[1][cmd.coef];
            end
            default: begin
                l_x0 = m0_reg;
                l_x1 = m1_reg;
                l_xq = qm_reg;
                l_y0 = slc_reg[0][cmd.coef];
                l_y1 = slc_reg[1][cmd.coef];
            end
        endcase
    end

    tti_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.lerp),
        .x0      (l_x0),
        .x1      (l_x1),
        .xq      (l_xq),
        .y0      (l_y0),
        .y1      (l_y1),
        .done    (l_done),
        .y       (l_y),
        .zw      (l_zw)
    );

    always_ff @(posedge aclk) begin
        tv_lo_reg <= cmd.rd_lo;
        tv_hi_reg <= cmd.rd_hi;
        if (tv_lo_reg) begin
            tlo_reg[0] <= tl_q;
            tlo_reg[1] <= td_q;
            tlo_reg[2] <= tm_q;
        end
        if (tv_hi_reg) begin
            thi_reg[0] <= tl_q;
            thi_reg[1] <= td_q;
            thi_reg[2] <= tm_q;
        end
        if (cmd.lerp) begin
            lt_lvl_reg <= cmd.lvl;
            lt_s_reg   <= cmd.slice;
            lt_r_reg   <= cmd.row;
            lt_c_reg   <= cmd.coef;
        end
        if (l_done) begin
            unique case (lt_lvl_reg)
                LV_DEFL: row_reg[lt_r_reg][lt_c_reg] <= l_y;
                LV_AOA:  slc_reg[lt_s_reg][lt_c_reg] <= l_y;
                default: res_reg[lt_c_reg] <= l_y;
            endcase
        end
        if (cmd.load_out) begin
            out_lift_reg <= res_reg[0];
            out_drag_reg <= res_reg[1];
            out_mom_reg  <= res_reg[2];
            out_sts_reg  <= zw_reg ? STS_ZERO : (ext_reg ? STS_EXTRAP : STS_INSIDE);
        end
        if (!aresetn) begin
            tv_lo_reg <= 1'b0;
            tv_hi_reg <= 1'b0;
        end
    end

    assign sts.scan_done = sc_done_reg;
    assign sts.lerp_done = l_done;
    assign m_lift_out    = out_lift_reg;
    assign m_drag_out    = out_drag_reg;
    assign m_moment_out  = out_mom_reg;
    assign m_status      = out_sts_reg;

endmodule

`default_nettype wire

[sv/tti_ctrl.sv]
// Controller: sequences scans, coefficient reads and interpolations per query
// and owns both handshakes. Depends on tti_pkg.
`default_nettype none

module tti_ctrl
    import tti_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [REQW-1:0] s_req_type,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output cmd_t                 cmd,
    input  wire sts_t            sts
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_GO, ST_SCAN_WAIT, ST_RD_LO, ST_RD_HI, ST_RD_W,
        ST_LERP_GO, ST_LERP_WAIT, ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    axis_t      ax_reg, ax_next;
    lvl_t       lvl_reg, lvl_next;
    logic       s_reg, s_next;
    logic       r_reg, r_next;
    logic [1:0] c_reg, c_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        ax_next      = ax_reg;
        lvl_next     = lvl_reg;
        s_next       = s_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.axis     = ax_reg;
        cmd.lvl      = lvl_reg;
        cmd.slice    = s_reg;
        cmd.row      = r_reg;
        cmd.coef     = c_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_QUERY) begin
                        cmd.cap    = 1'b1;
                        ax_next    = AX_MACH;
                        s_next     = 1'b0;
                        state_next = ST_SCAN_GO;
                    end else begin
                        cmd.wr = 1'b1;
                    end
                end
            end
            ST_SCAN_GO: begin
                cmd.scan   = 1'b1;
                state_next = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT: begin
                if (sts.scan_done) begin
                    unique case (ax_reg)
                        AX_MACH: begin
                            ax_next    = AX_DEFL;
                            state_next = ST_SCAN_GO;
                        end
                        AX_DEFL: begin
                            ax_next    = AX_AOA;
                            state_next = ST_SCAN_GO;
                        end
                        default: begin
                            r_next     = 1'b0;
                            state_next = ST_RD_LO;
                        end
                    endcase
                end
            end
            ST_RD_LO: begin
                cmd.rd_lo  = 1'b1;
                state_next = ST_RD_HI;
            end
            ST_RD_HI: begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_RD_W;
            end
            ST_RD_W: begin
                c_next     = 2'd0;
                lvl_next   = LV_DEFL;
                state_next = ST_LERP_GO;
            end
            ST_LERP_GO: begin
                cmd.lerp   = 1'b1;
                state_next = ST_LERP_WAIT;
            end
            ST_LERP_WAIT: begin
                if (sts.lerp_done) begin
                    if (c_reg != 2'd2) begin
                        c_next     = c_reg + 1'b1;
                        state_next = ST_LERP_GO;
                    end else begin
                        c_next = 2'd0;
                        unique case (lvl_reg)
                            LV_DEFL: begin
                                if (!r_reg) begin
                                    r_next     = 1'b1;
                                    state_next = ST_RD_LO;
                                end else begin
                                    lvl_next   = LV_AOA;
                                    state_next = ST_LERP_GO;
                                end
                            end
                            LV_AOA: begin
                                if (!s_reg) begin
                                    s_next     = 1'b1;
                                    ax_next    = AX_AOA;
                                    state_next = ST_SCAN_GO;
                                end else begin
                                    lvl_next   = LV_MACH;
                                    state_next = ST_LERP_GO;
                                end
                            end
                            default: state_next = ST_OUT;
                        endcase
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ax_reg      <= AX_MACH;
            lvl_reg     <= LV_DEFL;
            s_reg       <= 1'b0;
            r_reg       <= 1'b0;
            c_reg       <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ax_reg      <= ax_next;
            lvl_reg     <= lvl_next;
            s_reg       <= s_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    a_query_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_QUERY)
        |=> (state_reg == ST_SCAN_GO && ax_reg == AX_MACH))
        else $error("Accepted query did not start the mach scan.");

    a_scan_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.scan_done |-> state_reg == ST_SCAN_WAIT)
        else $error("Scan finished while the controller was not waiting for it.");

    a_lerp_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.lerp_done |-> state_reg == ST_LERP_WAIT)
        else $error("Interpolation finished while the controller was not waiting.");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("Result register loaded over an undelivered word.");

endmodule

`default_nettype wire

[sv/trilinear_table_interpolator.sv]
// Trilinear coefficient lookup. The shared interpolation unit does 21 steps, each
// around a 47-step restoring divider; a query also makes four breakpoint scans
// and four coefficient fetches. A finished result waits in an output register
// while the next word is accepted. No clearing pass follows reset.
`default_nettype none

module trilinear_table_interpolator
    import tti_pkg::*;
#(
    parameter int MACH_MAX = 16,
    parameter int AOA_MAX  = 32,
    parameter int DEFL_MAX = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFGIW-1:0]        cfg_index,
    input  wire logic [CFGDW-1:0]        cfg_wr_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [REQW-1:0]         s_req_type,
    input  wire logic [3:0]              s_row_mach,
    input  wire logic [4:0]              s_row_aoa,
    input  wire logic [3:0]              s_row_defl,
    input  wire logic signed [BPW-1:0]   s_bp_value,
    input  wire logic signed [COEFW-1:0] s_coef_lift,
    input  wire logic signed [COEFW-1:0] s_coef_drag,
    input  wire logic signed [COEFW-1:0] s_coef_moment,
    input  wire logic signed [BPW-1:0]   s_query_mach,
    input  wire logic signed [BPW-1:0]   s_query_aoa,
    input  wire logic signed [BPW-1:0]   s_query_defl,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [COEFW-1:0]      m_lift_out,
    output logic signed [COEFW-1:0]      m_drag_out,
    output logic signed [COEFW-1:0]      m_moment_out,
    output logic [STW-1:0]               m_status
);

    cmd_t cmd;
    sts_t sts;

    tti_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    tti_datapath #(
        .MACH_MAX (MACH_MAX),
        .AOA_MAX  (AOA_MAX),
        .DEFL_MAX (DEFL_MAX)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_req_type    (s_req_type),
        .s_row_mach    (s_row_mach),
        .s_row_aoa     (s_row_aoa),
        .s_row_defl    (s_row_defl),
        .s_bp_value    (s_bp_value),
        .s_coef_lift   (s_coef_lift),
        .s_coef_drag   (s_coef_drag),
        .s_coef_moment (s_coef_moment),
        .s_query_mach  (s_query_mach),
        .s_query_aoa   (s_query_aoa),
        .s_query_defl  (s_query_defl),
        .cmd           (cmd),
        .sts           (sts),
        .m_lift_out    (m_lift_out),
        .m_drag_out    (m_drag_out),
        .m_moment_out  (m_moment_out),
        .m_status      (m_status)
    );

endmodule

`default_nettype wire

[tb/trilinear_table_interpolator_checker.sv]
// Checker for the trilinear table interpolator: mirrors the breakpoint lists,
// coefficient tables and count registers, predicts each query and compares.
// Depends on tti_pkg for field widths, request, status and register codes.
module trilinear_table_interpolator_checker
    import tti_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFGIW-1:0]        cfg_index,
    input  wire logic [CFGDW-1:0]        cfg_wr_data,
    input  wire logic                    s_valid,
    input  wire logic                    s_ready,
    input  wire logic [REQW-1:0]         s_req_type,
    input  wire logic [3:0]              s_row_mach,
    input  wire logic [4:0]              s_row_aoa,
    input  wire logic [3:0]              s_row_defl,
    input  wire logic signed [BPW-1:0]   s_bp_value,
    input  wire logic signed [COEFW-1:0] s_coef_lift,
    input  wire logic signed [COEFW-1:0] s_coef_drag,
    input  wire logic signed [COEFW-1:0] s_coef_moment,
    input  wire logic signed [BPW-1:0]   s_query_mach,
    input  wire logic signed [BPW-1:0]   s_query_aoa,
    input  wire logic signed [BPW-1:0]   s_query_defl,
    input  wire logic                    m_valid,
    input  wire logic                    m_ready,
    input  wire logic signed [COEFW-1:0] m_lift_out,
    input  wire logic signed [COEFW-1:0] m_drag_out,
    input  wire logic signed [COEFW-1:0] m_moment_out,
    input  wire logic [STW-1:0]          m_status,
    output int                           mismatches,
    output int                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [COEFW-1:0] lift;
        logic signed [COEFW-1:0] drag;
        logic signed [COEFW-1:0] moment;
        logic [STW-1:0]          status;
    } coef_set_t;

    logic [4:0] mach_cnt = 5'd2;
    logic [5:0] aoa_cnt = 6'd2;
    logic [4:0] defl_cnt = 5'd2;
    logic signed [BPW-1:0] mach_bp [16];
    logic signed [BPW-1:0] aoa_bp [16][32];
    logic signed [BPW-1:0] defl_bp [16];
    logic signed [COEFW-1:0] coef_tab [3][16][32][16];
    coef_set_t expected_coefs [$];
    coef_set_t want;

    initial begin
        mismatches = 0;
        outstanding = 0;
        foreach (mach_bp[i]) mach_bp[i] = '0;
        foreach (defl_bp[i]) defl_bp[i] = '0;
        foreach (aoa_bp[i, j]) aoa_bp[i][j] = '0;
        foreach (coef_tab[c, m, a, d]) coef_tab[c][m][a][d] = '0;
    end

    function automatic int used_count(int raw, int lim);
        if (raw < 2) return 2;
        if (raw > lim) return lim;
        return raw;
    endfunction

    function automatic longint bp_at(axis_t ax, int m, int i);
        case (ax)
            AX_MACH: return longint'(mach_bp[i]);
            AX_AOA:  return longint'(aoa_bp[m][i]);
            default: return longint'(defl_bp[i]);
        endcase
    endfunction

    // Lower index of the bracketing interval; interior hits take the interval above.
    function automatic int bracket(axis_t ax, int m, int n, longint x, inout bit ext);
        int idx;
        idx = 0;
        for (int i = 1; i + 1 < n; i++) begin
            if (bp_at(ax, m, i) <= x) idx = i;
        end
        if (x < bp_at(ax, m, 0) || x > bp_at(ax, m, n - 1)) ext = 1'b1;
        return idx;
    endfunction

    function automatic longint lerp_step(longint x0, longint y0, longint x1, longint y1,
                                         longint x, inout bit zw);
        longint den, num, an, ad, q, y;
        den = x1 - x0;
        if (den == 0) begin
            zw = 1'b1;
            return y0;
        end
        num = (y1 - y0) * (x - x0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an + ad / 2) / ad;
        if ((num < 0) != (den < 0)) q = -q;
        y = y0 + q;
        if (y > 64'sd8388607) y = 64'sd8388607;
        if (y < -64'sd8388608) y = -64'sd8388608;
        return y;
    endfunction

    function automatic coef_set_t predict_coefs(longint qm, longint qa, longint qd);
        int nm, na, nd, mi, di, ai, m;
        bit ext, zw;
        longint row [2][3];
        longint slc [2][3];
        longint res [3];
        coef_set_t r;
        ext = 1'b0;
        zw = 1'b0;
        nm = used_count(int'(mach_cnt), 16);
        na = used_count(int'(aoa_cnt), 32);
        nd = used_count(int'(defl_cnt), 16);
        mi = bracket(AX_MACH, 0, nm, qm, ext);
        di = bracket(AX_DEFL, 0, nd, qd, ext);
        for (int s = 0; s < 2; s++) begin
            m = mi + s;
            ai = bracket(AX_AOA, m, na, qa, ext);
            for (int rr = 0; rr < 2; rr++) begin
                for (int c = 0; c < 3; c++) begin
                    row[rr][c] = lerp_step(defl_bp[di], coef_tab[c][m][ai+rr][di],
                                           defl_bp[di+1], coef_tab[c][m][ai+rr][di+1],
                                           qd, zw);
                end
            end
            for (int c = 0; c < 3; c++) begin
                slc[s][c] = lerp_step(aoa_bp[m][ai], row[0][c], aoa_bp[m][ai+1],
                                      row[1][c], qa, zw);
            end
        end
        for (int c = 0; c < 3; c++) begin
            res[c] = lerp_step(mach_bp[mi], slc[0][c], mach_bp[mi+1], slc[1][c], qm, zw);
        end
        r.lift = res[0][COEFW-1:0];
        r.drag = res[1][COEFW-1:0];
        r.moment = res[2][COEFW-1:0];
        r.status = zw ? STS_ZERO : (ext ? STS_EXTRAP : STS_INSIDE);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint exp_val);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, field, got,
                 exp_val);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            mach_cnt = 5'd2;
            aoa_cnt = 6'd2;
            defl_cnt = 5'd2;
            expected_coefs.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_coefs.size() == 0) begin
                    report_mismatch("unexpected result word", 0, 0);
                end else begin
                    want = expected_coefs.pop_front();
                    if (m_lift_out !== want.lift)
                        report_mismatch("lift", m_lift_out, want.lift);
                    if (m_drag_out !== want.drag)
                        report_mismatch("drag", m_drag_out, want.drag);
                    if (m_moment_out !== want.moment)
                        report_mismatch("moment", m_moment_out, want.moment);
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_MACH_COUNT: mach_cnt = cfg_wr_data[4:0];
                    CFG_AOA_COUNT:  aoa_cnt = cfg_wr_data[5:0];
                    CFG_DEFL_COUNT: defl_cnt = cfg_wr_data[4:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_req_type)
                    REQ_MACH_BP: mach_bp[s_row_mach] = s_bp_value;
                    REQ_AOA_BP:  aoa_bp[s_row_mach][s_row_aoa] = s_bp_value;
                    REQ_DEFL_BP: defl_bp[s_row_defl] = s_bp_value;
                    REQ_COEF: begin
                        coef_tab[0][s_row_mach][s_row_aoa][s_row_defl] = s_coef_lift;
                        coef_tab[1][s_row_mach][s_row_aoa][s_row_defl] = s_coef_drag;
                        coef_tab[2][s_row_mach][s_row_aoa][s_row_defl] = s_coef_moment;
                    end
                    REQ_QUERY: expected_coefs.insert(expected_coefs.size(),
                                                     predict_coefs(s_query_mach,
                                                                   s_query_aoa,
                                                                   s_query_defl));
                    default: ;
                endcase
            end
        end
        outstanding <= expected_coefs.size();
    end

endmodule

[tb/trilinear_table_interpolator_tb.sv]
// Testbench top for the trilinear table interpolator: clock, reset, load and
// query stimulus with random idling, and the verdict. Needs tti_pkg, the block
// and trilinear_table_interpolator_checker.
module trilinear_table_interpolator_tb
    import tti_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFGIW-1:0] cfg_index = '0;
    logic [CFGDW-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [REQW-1:0] s_req_type = REQ_QUERY;
    logic [3:0] s_row_mach = '0;
    logic [4:0] s_row_aoa = '0;
    logic [3:0] s_row_defl = '0;
    logic signed [BPW-1:0] s_bp_value = '0;
    logic signed [COEFW-1:0] s_coef_lift = '0;
    logic signed [COEFW-1:0] s_coef_drag = '0;
    logic signed [COEFW-1:0] s_coef_moment = '0;
    logic signed [BPW-1:0] s_query_mach = '0;
    logic signed [BPW-1:0] s_query_aoa = '0;
    logic signed [BPW-1:0] s_query_defl = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [COEFW-1:0] m_lift_out;
    logic signed [COEFW-1:0] m_drag_out;
    logic signed [COEFW-1:0] m_moment_out;
    logic [STW-1:0] m_status;
    int mismatches;
    int outstanding;

    logic signed [BPW-1:0] mach_img [16];
    logic signed [BPW-1:0] aoa_img [16][32];
    logic signed [BPW-1:0] defl_img [16];
    bit cell_loaded [8192];
    int n_mach = 2;
    int n_aoa = 2;
    int n_defl = 2;
    int words_sent = 0;
    bit steady_src = 1'b0;
    bit steady_sink = 1'b0;
    int sink_hold = 0;

    always #5 aclk = ~aclk;

    trilinear_table_interpolator dut (.*);
    trilinear_table_interpolator_checker checker_i (.*);

    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (steady_sink || $urandom_range(0, 99) < 70) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                                      : $urandom_range(0, 3);
        end
    end

    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int clamp_count(int raw, int lim);
        if (raw < 2) return 2;
        if (raw > lim) return lim;
        return raw;
    endfunction

    function automatic int lower_index(axis_t ax, int m, int n, int x);
        int idx, v;
        idx = 0;
        for (int i = 1; i + 1 < n; i++) begin
            v = (ax == AX_MACH) ? mach_img[i] : (ax == AX_AOA) ? aoa_img[m][i] : defl_img[i];
            if (v <= x) idx = i;
        end
        return idx;
    endfunction

    function automatic logic signed [COEFW-1:0] rand_coef();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, 524288)) - 262144;
    endfunction

    task automatic send_word(logic [REQW-1:0] req, logic [3:0] rm, logic [4:0] ra,
                             logic [3:0] rd, logic signed [BPW-1:0] bp,
                             logic signed [COEFW-1:0] cl, logic signed [COEFW-1:0] cd,
                             logic signed [COEFW-1:0] cm, logic signed [BPW-1:0] qm,
                             logic signed [BPW-1:0] qa, logic signed [BPW-1:0] qd);
        @(negedge aclk);
        s_req_type = req;
        s_row_mach = rm;
        s_row_aoa = ra;
        s_row_defl = rd;
        s_bp_value = bp;
        s_coef_lift = cl;
        s_coef_drag = cd;
        s_coef_moment = cm;
        s_query_mach = qm;
        s_query_aoa = qa;
        s_query_defl = qd;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        case (req)
            REQ_MACH_BP: mach_img[rm] = bp;
            REQ_AOA_BP:  aoa_img[rm][ra] = bp;
            REQ_DEFL_BP: defl_img[rd] = bp;
            REQ_COEF:    cell_loaded[{rm, ra, rd}] = 1'b1;
            default: ;
        endcase
    endtask

    task automatic write_bp(logic [REQW-1:0] req, int m, int a, int d, int v);
        send_word(req, m, a, d, v, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom);
    endtask

    task automatic write_cell(int m, int a, int d, logic signed [COEFW-1:0] cl,
                              logic signed [COEFW-1:0] cd, logic signed [COEFW-1:0] cm);
        send_word(REQ_COEF, m, a, d, $urandom, cl, cd, cm, $urandom, $urandom, $urandom);
    endtask

    // Loads any coefficient cell the query will read before sending it.
    task automatic query_point(int qm, int qa, int qd);
        int mi, di, ai;
        qm = int'($signed(BPW'(qm)));
        qa = int'($signed(BPW'(qa)));
        qd = int'($signed(BPW'(qd)));
        mi = lower_index(AX_MACH, 0, n_mach, qm);
        di = lower_index(AX_DEFL, 0, n_defl, qd);
        for (int s = 0; s < 2; s++) begin
            ai = lower_index(AX_AOA, mi + s, n_aoa, qa);
            for (int r = 0; r < 2; r++) begin
                for (int k = 0; k < 2; k++) begin
                    if (!cell_loaded[(mi + s) * 512 + (ai + r) * 16 + di + k])
                        write_cell(mi + s, ai + r, di + k, rand_coef(), rand_coef(),
                                   rand_coef());
                end
            end
        end
        send_word(REQ_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, qm, qa, qd);
    endtask

    task automatic pause_sender();
        int n;
        if (steady_src || $urandom_range(0, 99) < 65) return;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 3);
        @(negedge aclk);
        s_valid = 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFGIW-1:0] idx, int data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_axis(logic [REQW-1:0] req, int m, int n);
        int v;
        v = $urandom_range(0, 40000) - 20000;
        for (int i = 0; i < n; i++) begin
            write_bp(req, (req == REQ_MACH_BP) ? i : m, i, i, v);
            v += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 400);
        end
    endtask

    function automatic int pick_coord(int lo_v, int hi_v, int hit_v);
        int r, a, b;
        r = $urandom_range(0, 99);
        a = (lo_v < hi_v) ? lo_v : hi_v;
        b = (lo_v < hi_v) ? hi_v : lo_v;
        if (r < 65) return a - 300 + $urandom_range(0, b - a + 600);
        if (r < 80) return hit_v;
        if (r < 90) return $signed(20'($urandom));
        return (r < 95) ? -524288 : 524287;
    endfunction

    // The word budget of a phase includes its breakpoint loads.
    task automatic run_phase(int mc, int ac, int dc, int n_items);
        int r, first, m, i;
        drain();
        first = words_sent;
        steady_src = ($urandom_range(0, 3) == 0);
        steady_sink = ($urandom_range(0, 3) == 0);
        write_reg(CFG_MACH_COUNT, mc);
        write_reg(CFG_AOA_COUNT, ac);
        write_reg(CFG_DEFL_COUNT, dc);
        n_mach = clamp_count(mc & 31, 16);
        n_aoa = clamp_count(ac & 63, 32);
        n_defl = clamp_count(dc & 31, 16);
        load_axis(REQ_MACH_BP, 0, n_mach);
        load_axis(REQ_DEFL_BP, 0, n_defl);
        for (m = 0; m < n_mach; m++) load_axis(REQ_AOA_BP, m, n_aoa);
        while (words_sent - first < n_items) begin
            pause_sender();
            if ($urandom_range(0, 59) == 0) drain();
            r = $urandom_range(0, 99);
            m = $urandom_range(0, n_mach - 1);
            if (r < 58) begin
                query_point(pick_coord(mach_img[0], mach_img[n_mach-1],
                                       mach_img[$urandom_range(0, n_mach - 1)]),
                            pick_coord(aoa_img[0][0], aoa_img[0][n_aoa-1],
                                       aoa_img[m][$urandom_range(0, n_aoa - 1)]),
                            pick_coord(defl_img[0], defl_img[n_defl-1],
                                       defl_img[$urandom_range(0, n_defl - 1)]));
            end else if (r < 80) begin
                write_cell($urandom, $urandom, $urandom, rand_coef(), rand_coef(),
                           rand_coef());
            end else if (r < 84) begin
                i = $urandom_range(0, n_defl - 1);
                write_bp(REQ_DEFL_BP, 0, 0, i, defl_img[i] + $urandom_range(0, 128) - 64);
            end else if (r < 90) begin
                // Any entry, in use or beyond the counts in use, may take a fully random value.
                write_bp($urandom_range(0, 2), $urandom, $urandom, $urandom, $urandom);
            end else begin
                send_word($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset counts: a two by two by two grid.
        write_bp(REQ_MACH_BP, 0, 0, 0, 0);
        write_bp(REQ_MACH_BP, 1, 0, 0, 256);
        write_bp(REQ_DEFL_BP, 0, 0, 0, -512);
        write_bp(REQ_DEFL_BP, 0, 0, 1, 512);
        write_bp(REQ_AOA_BP, 0, 0, 0, -1280);
        write_bp(REQ_AOA_BP, 0, 1, 0, 2560);
        write_bp(REQ_AOA_BP, 1, 0, 0, -1024);
        write_bp(REQ_AOA_BP, 1, 1, 0, 2048);
        write_cell(0, 0, 0, -24'sd8388608, 24'sd8388607, -24'sd8388608);
        write_cell(1, 1, 1, 24'sd8388607, -24'sd8388608, 24'sd8388607);
        query_point(128, 640, 0);
        query_point(0, -1280, -512);
        query_point(256, 2560, 512);
        query_point(-5000, 0, 0);
        query_point(128, 99999, 0);
        query_point(128, 0, -100000);
        query_point(524287, 524287, 524287);
        query_point(-524288, -524288, -524288);
        write_bp(REQ_DEFL_BP, 0, 0, 1, -512);
        query_point(128, 640, -512);
        query_point(128, 640, 300);
        write_bp(REQ_DEFL_BP, 0, 0, 1, 512);
        write_bp(REQ_MACH_BP, 1, 0, 0, 0);
        query_point(0, 640, 0);
        write_bp(REQ_MACH_BP, 1, 0, 0, 256);
        for (int k = 5; k < 8; k++) begin
            send_word(k, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        end

        run_phase(0, 1, 0, 130);
        run_phase(3, 4, 3, 130);
        run_phase(16, 2, 16, 150);
        run_phase(2, 32, 3, 150);
        drain();
        write_reg(2'd3, $urandom_range(0, 63));
        run_phase(63, 2, 63, 150);
        run_phase(2, 63, 2, 150);
        run_phase(5, 9, 4, 130);
        run_phase(7, 12, 6, 130);
        run_phase($urandom_range(0, 20), $urandom_range(0, 4), $urandom_range(0, 20), 100);

        drain();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/tti_pkg.sv
sv/tti_lerp.sv
sv/tti_datapath.sv
sv/tti_ctrl.sv
sv/trilinear_table_interpolator.sv
tb/trilinear_table_interpolator_checker.sv
tb/trilinear_table_interpolator_tb.sv
